// ----- src/cle_pkg.sv -----
// ---------------------------------------------------------------------------
// cle_pkg
// Types and character codes shared by the console line editor modules.
// ---------------------------------------------------------------------------
package cle_pkg;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_ETX      = 8'h03;  // Ctrl-C
  localparam logic [7:0] CH_EOT      = 8'h04;  // Ctrl-D
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_FF       = 8'h0C;  // Ctrl-L
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_DLE      = 8'h10;  // Ctrl-P
  localparam logic [7:0] CH_NAK      = 8'h15;  // Ctrl-U
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_A        = 8'h41;
  localparam logic [7:0] CH_B        = 8'h42;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_DEL      = 8'h7F;
  localparam logic [7:0] CH_NOECHO   = 8'hE0;  // codes at or above are silent
  localparam logic [7:0] CH_UP       = 8'hE2;
  localparam logic [7:0] CH_DOWN     = 8'hE3;

  typedef enum logic [2:0] {
    EK_NONE    = 3'd0,
    EK_CHAR    = 3'd1,
    EK_ERASE   = 3'd2,
    EK_BELL    = 3'd3,
    EK_CARET_C = 3'd4
  } echo_kind_e;

  typedef enum logic [1:0] {
    RS_DATA     = 2'd0,
    RS_EOF      = 2'd1,
    RS_EMPTY    = 2'd2,
    RS_NOT_READ = 2'd3
  } read_status_e;

  typedef enum logic [1:0] {
    ESC_NORMAL  = 2'd0,
    ESC_SEEN    = 2'd1,
    ESC_BRACKET = 2'd2
  } esc_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_KILL = 2'd2,
    ST_EMIT = 2'd3
  } core_state_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_char;
    logic       first_of_read;
  } in_item_t;

  typedef struct packed {
    echo_kind_e   echo_kind;
    logic [7:0]   echo_char;
    logic [7:0]   erase_count;
    logic         line_ready;
    logic         interrupt_request;
    logic         dump_request;
    read_status_e read_status;
    logic [7:0]   read_byte;
    logic         read_line_end;
    logic [31:0]  dropped_count;
  } out_item_t;

  localparam out_item_t RESULT_BLANK = '{
    echo_kind:         EK_NONE,
    echo_char:         8'h00,
    erase_count:       8'h00,
    line_ready:        1'b0,
    interrupt_request: 1'b0,
    dump_request:      1'b0,
    read_status:       RS_NOT_READ,
    read_byte:         8'h00,
    read_line_end:     1'b0,
    dropped_count:     32'h0
  };

endpackage

// ----- src/cle_stream_if.sv -----
// ---------------------------------------------------------------------------
// cle_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ---------------------------------------------------------------------------
interface cle_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ----- src/cle_ring.sv -----
// ---------------------------------------------------------------------------
// cle_ring
// Byte ring storage: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module cle_ring #(
  parameter int Depth = 128,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- src/cle_out_reg.sv -----
// ---------------------------------------------------------------------------
// cle_out_reg
// Output register between the editor core and the result channel.
// ---------------------------------------------------------------------------
module cle_out_reg (
  input  logic         clk_i,
  input  logic         rst_ni,
  cle_stream_if.sink   res_i,
  cle_stream_if.source out_o
);
  import cle_pkg::*;

  logic      valid_q, valid_d;
  out_item_t data_q;
  logic      load;

  assign res_i.ready   = !valid_q || out_o.ready;
  assign load          = res_i.valid && res_i.ready;
  assign valid_d       = load || (valid_q && !out_o.ready);
  assign out_o.valid   = valid_q;
  assign out_o.payload = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= res_i.payload;
    end
  end

endmodule

// ----- src/cle_core.sv -----
// ---------------------------------------------------------------------------
// cle_core
// Line editing sequencer: ring indices, escape decoding, kill-line walk,
// committed reads, drop counter and configuration register.
// ---------------------------------------------------------------------------
module cle_core #(
  parameter int Depth = 128,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  cle_stream_if.sink       in_i,
  cle_stream_if.sink       cfg_i,
  cle_stream_if.source     res_o,
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output logic [7:0]       mem_wdata_o,
  output logic             mem_re_o,
  output logic [AddrW-1:0] mem_raddr_o,
  input  logic [7:0]       mem_rdata_i
);
  import cle_pkg::*;

  localparam int IdxW = $clog2(2 * Depth);
  localparam logic [IdxW-1:0] IdxLast  = IdxW'(2 * Depth - 1);
  localparam logic [IdxW-1:0] DepthIdx = IdxW'(Depth);
  localparam logic [IdxW-1:0] AlmostFull = IdxW'(Depth - 1);
  localparam logic [IdxW:0]   IdxMod   = (IdxW + 1)'(2 * Depth);

  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] a);
    return (a == IdxLast) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] idx_dec(input logic [IdxW-1:0] a);
    return (a == '0) ? IdxLast : a - 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] idx_diff(input logic [IdxW-1:0] a,
                                                input logic [IdxW-1:0] b);
    logic [IdxW:0] wide;
    wide = (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + IdxMod - {1'b0, b});
    return wide[IdxW-1:0];
  endfunction

  function automatic logic [AddrW-1:0] slot(input logic [IdxW-1:0] a);
    logic [IdxW-1:0] s;
    s = (a >= DepthIdx) ? a - DepthIdx : a;
    return s[AddrW-1:0];
  endfunction

  core_state_e     state_q, state_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic [IdxW-1:0] cm_idx_q, cm_idx_d;
  logic [IdxW-1:0] ed_idx_q, ed_idx_d;
  esc_mode_e       esc_q, esc_d;
  logic [31:0]     drop_q, drop_d;
  logic            cr_q, cr_d;
  logic            first_q, first_d;
  logic [7:0]      cnt_q, cnt_d;
  out_item_t       res_q, res_d;

  assign in_i.ready    = (state_q == ST_IDLE);
  assign cfg_i.ready   = 1'b1;
  assign res_o.valid   = (state_q == ST_EMIT);
  assign res_o.payload = res_q;

  always_comb begin
    logic [7:0]      ch;
    logic            go;
    logic [IdxW-1:0] ed_nx;
    logic [7:0]      cnt_x;
    logic            done;

    state_d  = state_q;
    rd_idx_d = rd_idx_q;
    cm_idx_d = cm_idx_q;
    ed_idx_d = ed_idx_q;
    esc_d    = esc_q;
    drop_d   = drop_q;
    cr_d     = cr_q;
    first_d  = first_q;
    cnt_d    = cnt_q;
    res_d    = res_q;

    mem_we_o    = 1'b0;
    mem_waddr_o = slot(ed_idx_q);
    mem_wdata_o = 8'h00;
    mem_re_o    = 1'b0;
    mem_raddr_o = slot(rd_idx_q);

    ch    = in_i.payload.rx_char;
    go    = 1'b0;
    ed_nx = idx_inc(ed_idx_q);
    cnt_x = cnt_q;
    done  = 1'b0;

    if (cfg_i.valid) begin
      cr_d = cfg_i.payload;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          res_d   = RESULT_BLANK;
          state_d = ST_EMIT;
          if (in_i.payload.req_type) begin
            first_d = in_i.payload.first_of_read;
            if (rd_idx_q == cm_idx_q) begin
              res_d.read_status = RS_EMPTY;
            end else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = slot(rd_idx_q);
              state_d     = ST_READ;
            end
          end else begin
            case (ch) inside
              CH_ETX: begin
                res_d.echo_kind         = EK_CARET_C;
                res_d.interrupt_request = 1'b1;
              end
              CH_DLE: begin
                res_d.dump_request = 1'b1;
              end
              CH_NAK: begin
                if (ed_idx_q != cm_idx_q) begin
                  mem_re_o    = 1'b1;
                  mem_raddr_o = slot(idx_dec(ed_idx_q));
                  cnt_d       = 8'h00;
                  state_d     = ST_KILL;
                end
              end
              CH_BS, CH_DEL: begin
                if (ed_idx_q != cm_idx_q) begin
                  ed_idx_d          = idx_dec(ed_idx_q);
                  res_d.echo_kind   = EK_ERASE;
                  res_d.erase_count = 8'd1;
                end else if (idx_diff(ed_idx_q, rd_idx_q) < DepthIdx) begin
                  mem_we_o         = 1'b1;
                  mem_waddr_o      = slot(ed_idx_q);
                  mem_wdata_o      = CH_DEL;
                  ed_idx_d         = ed_nx;
                  cm_idx_d         = ed_nx;
                  res_d.line_ready = 1'b1;
                end
              end
              default: begin
                go    = 1'b1;
                esc_d = ESC_NORMAL;
                case (esc_q)
                  ESC_SEEN: begin
                    if (ch == CH_LBRACKET) begin
                      esc_d = ESC_BRACKET;
                      go    = 1'b0;
                    end
                  end
                  ESC_BRACKET: begin
                    if (ch == CH_A) begin
                      ch = CH_UP;
                    end else if (ch == CH_B) begin
                      ch = CH_DOWN;
                    end else begin
                      go = 1'b0;
                    end
                  end
                  default: begin
                    if (ch == CH_ESC) begin
                      esc_d = ESC_SEEN;
                      go    = 1'b0;
                    end
                  end
                endcase
                if (go) begin
                  if (ch == CH_NUL || idx_diff(ed_idx_q, rd_idx_q) >= DepthIdx) begin
                    if (drop_q != '1) begin
                      drop_d = drop_q + 32'd1;
                    end
                    res_d.echo_kind = EK_BELL;
                  end else if (!(ch == CH_CR && !cr_q)) begin
                    if (ch == CH_CR) begin
                      ch = CH_LF;
                    end
                    if (ch < CH_NOECHO && ch != CH_TAB && ch != CH_FF) begin
                      res_d.echo_kind = EK_CHAR;
                      res_d.echo_char = ch;
                    end
                    mem_we_o    = 1'b1;
                    mem_waddr_o = slot(ed_idx_q);
                    mem_wdata_o = ch;
                    ed_idx_d    = ed_nx;
                    if (ch == CH_LF || ch == CH_EOT || ch == CH_UP || ch == CH_DOWN ||
                        ch == CH_TAB || ch == CH_FF ||
                        idx_diff(ed_idx_q, rd_idx_q) == AlmostFull) begin
                      cm_idx_d         = ed_nx;
                      res_d.line_ready = 1'b1;
                    end
                  end
                end
              end
            endcase
          end
          res_d.dropped_count = drop_d;
        end
      end

      ST_READ: begin
        state_d = ST_EMIT;
        if (mem_rdata_i == CH_EOT) begin
          if (first_q) begin
            rd_idx_d = idx_inc(rd_idx_q);
          end
          res_d.read_status = RS_EOF;
        end else begin
          rd_idx_d            = idx_inc(rd_idx_q);
          res_d.read_status   = RS_DATA;
          res_d.read_byte     = mem_rdata_i;
          res_d.read_line_end = (mem_rdata_i == CH_LF);
        end
      end

      ST_KILL: begin
        if (mem_rdata_i == CH_LF) begin
          done = 1'b1;
        end else begin
          ed_nx    = idx_dec(ed_idx_q);
          ed_idx_d = ed_nx;
          cnt_x    = (cnt_q == 8'hFF) ? cnt_q : cnt_q + 8'd1;
          cnt_d    = cnt_x;
          if (ed_nx == cm_idx_q) begin
            done = 1'b1;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = slot(idx_dec(ed_nx));
          end
        end
        if (done) begin
          state_d = ST_EMIT;
          if (cnt_x != 8'h00) begin
            res_d.echo_kind   = EK_ERASE;
            res_d.erase_count = cnt_x;
          end
        end
      end

      ST_EMIT: begin
        if (res_o.ready) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_idx_q <= '0;
      cm_idx_q <= '0;
      ed_idx_q <= '0;
      esc_q    <= ESC_NORMAL;
      drop_q   <= '0;
      cr_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
      cm_idx_q <= cm_idx_d;
      ed_idx_q <= ed_idx_d;
      esc_q    <= esc_d;
      drop_q   <= drop_d;
      cr_q     <= cr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    cnt_q   <= cnt_d;
    res_q   <= res_d;
  end

endmodule

// ----- src/console_line_editor.sv -----
// A received byte or an empty read goes from the core result register into the output
// register; a read that returns a byte first waits on the registered ring read data.
// Kill line erases k bytes, one ring entry per cycle, and stops at the committed index or
// at a newline. Items are taken one at a time: a new item is accepted only once the last
// has left the core; output stalls hold the core in its emit state.
// Reset clears indices, escape state, drop counter and the CR setting; ring not cleared.
// ---------------------------------------------------------------------------
// console_line_editor
// Canonical console line discipline on a ring of received bytes.
// ---------------------------------------------------------------------------
module console_line_editor #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cle_stream_if.sink   in_i,
  cle_stream_if.sink   cfg_i,
  cle_stream_if.source out_o
);
  import cle_pkg::*;

  localparam int AddrW = $clog2(BUFFER_DEPTH);

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic [7:0]       mem_rdata;

  cle_stream_if #(.payload_t(out_item_t)) res_if ();

  cle_ring #(
    .Depth (BUFFER_DEPTH),
    .AddrW (AddrW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  cle_core #(
    .Depth (BUFFER_DEPTH),
    .AddrW (AddrW)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .res_o       (res_if.source),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  cle_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (res_if.sink),
    .out_o  (out_o)
  );

endmodule
